// ===== rtl/mfek_pkg.sv =====
// Package for the max-flow block: sizes, commands, sequencer states and the
// register map. Used by max_flow_edmonds_karp.
`timescale 1ns / 1ps
package mfek_pkg;
  localparam int MaxNodes   = 64;
  localparam int NodeBits   = $clog2(MaxNodes);
  localparam int CntBits    = NodeBits + 1;
  localparam int CapBits    = 16;
  localparam int ResBits    = CapBits + 1;
  localparam int FlowBits   = 22;
  localparam int AccBits    = 23;
  localparam int AddrBits   = 2 * NodeBits;
  localparam int Depth      = MaxNodes * MaxNodes;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;
  localparam logic [2:0] REG_NODES_ADDR = 3'd0;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_COPY_RD, ST_COPY_WR,
    ST_BFS_INIT, ST_POP, ST_SCAN_RD, ST_SCAN_CHK,
    ST_BN_PAR, ST_BN_RD, ST_BN_CMP,
    ST_AUG_PAR, ST_AUG_RD1, ST_AUG_WR1, ST_AUG_RD2, ST_AUG_WR2,
    ST_DONE, ST_OUT
  } state_t;
endpackage

// ===== rtl/mfek_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mfek_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/max_flow_edmonds_karp.sv =====
// Top level of the Edmonds-Karp max-flow block: sequencer, shared add/subtract
// unit, and the capacity, residual, parent and queue RAMs.
// Depends on mfek_pkg and mfek_ram.
//
// Usage: items enter on in_tvalid/in_tready with the command in in_tuser. A
// load item (command 0) writes one capacity into both directions of the 64x64
// capacity matrix, one direction a cycle, so no new load is taken until the
// second direction is written; loads return nothing. A solve item (command 1)
// copies the matrix into the residual RAM, reading and then writing each
// entry, then runs breadth-first searches, each from a start state, scanning
// the row of every dequeued vertex column by column. Each path found is
// walked twice, once for the bottleneck and once to update both directions
// of each edge. A rejected solve is answered without a search.
// The result item (max_flow on out_tdata, error on out_tuser) waits in an
// output register, so loads are still taken while the receiver stalls; a
// later solve holds at its end, taking no item, until that register is free.
// After reset all 4096 capacity RAM entries are cleared, one entry a cycle,
// with in_tready low; configuration writes are taken meanwhile. The node
// count register (address 0) resets to 64.
`timescale 1ns / 1ps
module max_flow_edmonds_karp
  import mfek_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tuser: command[0]
  input  logic        in_tuser,
  // tdata: edge_from[5:0], edge_to[11:6], edge_capacity[27:12],
  //        source_node[33:28], sink_node[39:34]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: max_flow[21:0], zero fill up to 23
  output logic [23:0] out_tdata,
  // tuser: error[0]
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  state_t state_r, state_nxt;

  logic [6:0] nodes_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_NODES_ADDR) ? {25'd0, nodes_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r <= 7'd64;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_NODES_ADDR) begin
      nodes_r <= cfg_pwdata[6:0];
    end
  end

  // Input fields.
  logic                cmd;
  logic [NodeBits-1:0] ea, eb, src_in, dst_in;
  logic [CapBits-1:0]  ecap;
  assign cmd    = in_tuser;
  assign ea     = in_tdata[5:0];
  assign eb     = in_tdata[11:6];
  assign ecap   = in_tdata[27:12];
  assign src_in = in_tdata[33:28];
  assign dst_in = in_tdata[39:34];

  // Working registers.
  logic [CntBits-1:0]  n_r, n_nxt;
  logic [NodeBits-1:0] src_r, src_nxt, dst_r, dst_nxt;
  logic [AddrBits:0]   idx_r, idx_nxt;       // sweep counter
  logic [NodeBits-1:0] v_r, v_nxt;           // current vertex / path node
  logic [NodeBits-1:0] u_r, u_nxt;           // parent on path
  logic [CntBits-1:0]  i_r, i_nxt;           // scan column
  logic [CntBits-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [MaxNodes-1:0] seen_r, seen_nxt;
  logic [ResBits-1:0]  bn_r, bn_nxt;
  logic [AccBits-1:0]  flow_r, flow_nxt;
  logic                err_r, err_nxt;
  logic                load_pend_r, load_pend_nxt;
  logic [NodeBits-1:0] la_r, la_nxt, lb_r, lb_nxt;
  logic [CapBits-1:0]  lc_r, lc_nxt;

  // Output register: holds one finished result until the receiver takes it.
  logic                hold_v_r;
  logic [FlowBits-1:0] hold_flow_r;
  logic                hold_err_r;
  logic                out_load;

  // RAM ports.
  logic                cap_we;
  logic [AddrBits-1:0] cap_wa, cap_ra;
  logic [CapBits-1:0]  cap_wd, cap_rd;
  logic                res_we;
  logic [AddrBits-1:0] res_wa, res_ra;
  logic [ResBits-1:0]  res_wd, res_rd;
  logic                par_we;
  logic [NodeBits-1:0] par_wa, par_ra, par_wd, par_rd;
  logic                q_we;
  logic [NodeBits-1:0] q_wa, q_ra, q_wd, q_rd;

  mfek_ram #(.Width(CapBits), .Depth(Depth)) u_cap (
    .clk(clk), .we(cap_we), .waddr(cap_wa), .wdata(cap_wd), .raddr(cap_ra), .rdata(cap_rd));
  mfek_ram #(.Width(ResBits), .Depth(Depth)) u_res (
    .clk(clk), .we(res_we), .waddr(res_wa), .wdata(res_wd), .raddr(res_ra), .rdata(res_rd));
  mfek_ram #(.Width(NodeBits), .Depth(MaxNodes)) u_par (
    .clk(clk), .we(par_we), .waddr(par_wa), .wdata(par_wd), .raddr(par_ra), .rdata(par_rd));
  mfek_ram #(.Width(NodeBits), .Depth(MaxNodes)) u_q (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  // Shared add/subtract unit on the residual data path.
  logic             alu_sub;
  logic [ResBits-1:0] alu_b, alu_y;
  assign alu_y = alu_sub ? (res_rd - alu_b) : (res_rd + alu_b);

  assign in_tready  = (state_r == ST_IDLE) && !load_pend_r;
  assign out_tvalid = hold_v_r;
  assign out_tdata  = {2'b00, hold_flow_r};
  assign out_tuser  = hold_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      hold_flow_r <= '0;
      hold_err_r  <= 1'b0;
    end else if (out_load) begin
      hold_v_r    <= 1'b1;
      hold_flow_r <= flow_r[FlowBits-1:0];
      hold_err_r  <= err_r;
    end else if (out_tready) begin
      hold_v_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      load_pend_r <= 1'b0;
      flow_r      <= '0;
      err_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      load_pend_r <= load_pend_nxt;
      flow_r      <= flow_nxt;
      err_r       <= err_nxt;
    end
    n_r <= n_nxt; src_r <= src_nxt; dst_r <= dst_nxt; v_r <= v_nxt; u_r <= u_nxt;
    i_r <= i_nxt; head_r <= head_nxt; tail_r <= tail_nxt; seen_r <= seen_nxt;
    bn_r <= bn_nxt; la_r <= la_nxt; lb_r <= lb_nxt; lc_r <= lc_nxt;
  end

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; load_pend_nxt = 1'b0;
    flow_nxt = flow_r; err_nxt = err_r; out_load = 1'b0;
    n_nxt = n_r; src_nxt = src_r; dst_nxt = dst_r; v_nxt = v_r; u_nxt = u_r;
    i_nxt = i_r; head_nxt = head_r; tail_nxt = tail_r; seen_nxt = seen_r;
    bn_nxt = bn_r; la_nxt = la_r; lb_nxt = lb_r; lc_nxt = lc_r;
    cap_we = 1'b0; cap_wa = {la_r, lb_r}; cap_wd = lc_r; cap_ra = idx_r[AddrBits-1:0];
    res_we = 1'b0; res_wa = idx_r[AddrBits-1:0]; res_wd = {1'b0, cap_rd};
    res_ra = {v_r, i_r[NodeBits-1:0]};
    par_we = 1'b0; par_wa = i_r[NodeBits-1:0]; par_wd = v_r; par_ra = v_r;
    q_we = 1'b0; q_wa = tail_r[NodeBits-1:0]; q_wd = i_r[NodeBits-1:0];
    q_ra = head_r[NodeBits-1:0];
    alu_sub = 1'b1; alu_b = bn_r;

    unique case (state_r)
      ST_CLEAR: begin
        cap_we = 1'b1; cap_wa = idx_r[AddrBits-1:0]; cap_wd = '0;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (AddrBits+1)'(Depth - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (load_pend_r) begin
          cap_we = 1'b1; cap_wa = {lb_r, la_r};
        end else if (in_tvalid) begin
          if (cmd == CMD_LOAD) begin
            la_nxt = ea; lb_nxt = eb; lc_nxt = ecap;
            cap_we = 1'b1; cap_wa = {ea, eb}; cap_wd = ecap;
            load_pend_nxt = 1'b1;
          end else begin
            n_nxt = (nodes_r > 7'(MaxNodes)) ? CntBits'(MaxNodes) : nodes_r[CntBits-1:0];
            src_nxt = src_in; dst_nxt = dst_in;
            flow_nxt = '0;
            if (src_in == dst_in || {1'b0, src_in} >= nodes_r ||
                {1'b0, dst_in} >= nodes_r) begin
              err_nxt = 1'b1; state_nxt = ST_OUT;
            end else begin
              err_nxt = 1'b0; idx_nxt = '0; state_nxt = ST_COPY_RD;
            end
          end
        end
      end
      ST_COPY_RD: state_nxt = ST_COPY_WR;
      ST_COPY_WR: begin
        res_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        state_nxt = (idx_r == (AddrBits+1)'(Depth - 1)) ? ST_BFS_INIT : ST_COPY_RD;
      end
      ST_BFS_INIT: begin
        seen_nxt = '0; seen_nxt[src_r] = 1'b1;
        q_we = 1'b1; q_wa = '0; q_wd = src_r;
        head_nxt = '0; tail_nxt = CntBits'(1);
        state_nxt = ST_POP;
      end
      ST_POP: begin
        // The queue read data is registered, so it lags its address. Entry 0 is
        // written and the head reset in the start cycle, so the source is taken
        // directly; later heads have been steady through the whole row scan before.
        if (head_r == tail_r) begin
          state_nxt = ST_DONE;
        end else begin
          v_nxt = (head_r == '0) ? src_r : q_rd;
          head_nxt = head_r + 1'b1; i_nxt = '0;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (i_r == n_r) state_nxt = ST_POP;
        else state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        i_nxt = i_r + 1'b1;
        state_nxt = ST_SCAN_RD;
        if (res_rd != '0 && !seen_r[i_r[NodeBits-1:0]]) begin
          seen_nxt[i_r[NodeBits-1:0]] = 1'b1;
          par_we = 1'b1;
          if (i_r[NodeBits-1:0] == dst_r) begin
            v_nxt = dst_r; bn_nxt = '1;
            state_nxt = ST_BN_PAR;
          end else if (tail_r < CntBits'(MaxNodes)) begin
            q_we = 1'b1; tail_nxt = tail_r + 1'b1;
          end
        end
      end
      ST_BN_PAR: begin
        if (v_r == src_r) begin
          v_nxt = dst_r; state_nxt = ST_AUG_PAR;
        end else state_nxt = ST_BN_RD;
      end
      ST_BN_RD: begin
        u_nxt = par_rd; res_ra = {par_rd, v_r};
        state_nxt = ST_BN_CMP;
      end
      ST_BN_CMP: begin
        res_ra = {u_r, v_r};
        if (res_rd < bn_r) bn_nxt = res_rd;
        v_nxt = u_r; state_nxt = ST_BN_PAR;
      end
      ST_AUG_PAR: begin
        if (v_r == src_r) begin
          flow_nxt = flow_r + AccBits'(bn_r);
          state_nxt = ST_BFS_INIT;
        end else state_nxt = ST_AUG_RD1;
      end
      ST_AUG_RD1: begin
        u_nxt = par_rd; res_ra = {par_rd, v_r};
        state_nxt = ST_AUG_WR1;
      end
      ST_AUG_WR1: begin
        res_ra = {u_r, v_r};
        res_we = 1'b1; res_wa = {u_r, v_r}; alu_sub = 1'b1; res_wd = alu_y;
        state_nxt = ST_AUG_RD2;
      end
      ST_AUG_RD2: begin
        res_ra = {v_r, u_r};
        state_nxt = ST_AUG_WR2;
      end
      ST_AUG_WR2: begin
        res_ra = {v_r, u_r};
        res_we = 1'b1; res_wa = {v_r, u_r}; alu_sub = 1'b0; res_wd = alu_y;
        v_nxt = u_r; state_nxt = ST_AUG_PAR;
      end
      ST_DONE: state_nxt = ST_OUT;
      ST_OUT: begin
        // Move the result into the output register once it is free or being
        // emptied in this cycle.
        if (!hold_v_r || out_tready) begin
          out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
